/* hw/rtl/xt3_pkg.sv */
// XTEA3 package: widths, register indexes, round constants and mix function.
// Used by xt3_round, xtea3_block_cipher, xtea3_checker and testbench; no dependencies.
package xt3_pkg;

   localparam int WORD_W = 32;
   localparam int KEY_WORDS = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int DEF_MAX_ROUNDS = 64;
   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;
   localparam logic [4:0] ROT_MASK = 5'h1F;

   // register indexes
   localparam logic [2:0] REG_KEY01 = 3'd0;
   localparam logic [2:0] REG_KEY23 = 3'd1;
   localparam logic [2:0] REG_KEY45 = 3'd2;
   localparam logic [2:0] REG_KEY67 = 3'd3;
   localparam logic [2:0] REG_ROUNDS = 3'd4;

   localparam logic CMD_ENC = 1'b0;
   localparam logic CMD_DEC = 1'b1;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } block_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input logic [4:0] n);
      logic [2*WORD_W-1:0] dbl;
      begin
         dbl = {x, x} << (n & ROT_MASK);
         rotl = dbl[2*WORD_W-1:WORD_W];
      end
   endfunction

   function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] y,
                                             input logic [WORD_W-1:0] z,
                                             input logic [WORD_W-1:0] s,
                                             input logic [1:0] sel,
                                             input key_type key);
      logic [WORD_W-1:0] lft;
      logic [WORD_W-1:0] rgt;
      begin
         lft = (y << 4) + rotl(key[{1'b1, sel}], y[4:0]);
         rgt = (y >> 5) + rotl(key[{1'b0, sel}], y[31:27]);
         mix = lft ^ (z + s) ^ rgt;
      end
   endfunction

endpackage

/* hw/rtl/xt3_round.sv */
// One XTEA3 pipeline stage: one round (encrypt or decrypt) when enabled, else pass.
// Depends on xt3_pkg.
module xt3_round (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     valid_in,
   input  logic                     dec_in,
   input  logic                     active_in,
   input  logic [xt3_pkg::WORD_W-1:0] sum_in,
   input  xt3_pkg::block_type       blk_in,
   input  xt3_pkg::key_type         key,
   output logic                     valid_out,
   output logic                     dec_out,
   output logic [xt3_pkg::WORD_W-1:0] sum_out,
   output xt3_pkg::block_type       blk_out
);
   import xt3_pkg::*;

   logic              valid_ff;
   logic              dec_ff;
   logic [WORD_W-1:0] sum_ff, sum_in_w;
   block_type         blk_ff, blk_in_w;
   logic [WORD_W-1:0] s1, ta, tc;

   // compute one round
   always_comb begin
      s1 = 'x;
      ta = '0;
      tc = '0;
      blk_in_w = blk_in;
      sum_in_w = sum_in;
      if (active_in) begin
         if (dec_in == CMD_ENC) begin
            ta = blk_in.a + mix(blk_in.b, blk_in.d, sum_in, sum_in[1:0], key);
            s1 = sum_in + DELTA;
            tc = blk_in.c + mix(blk_in.d, blk_in.b, s1, s1[12:11], key);
            blk_in_w = '{a: blk_in.b, b: tc, c: blk_in.d, d: ta};
            sum_in_w = s1;
         end else begin
            // rotate back: a=d, b=a, c=b, d=c
            tc = blk_in.b - mix(blk_in.c, blk_in.a, sum_in, sum_in[12:11], key);
            s1 = sum_in - DELTA;
            ta = blk_in.d - mix(blk_in.a, blk_in.c, s1, s1[1:0], key);
            blk_in_w = '{a: ta, b: blk_in.a, c: tc, d: blk_in.c};
            sum_in_w = s1;
         end
      end
   end

   // hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         dec_ff <= dec_in;
         sum_ff <= sum_in_w;
         blk_ff <= blk_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign dec_out   = dec_ff;
   assign sum_out   = sum_ff;
   assign blk_out   = blk_ff;
endmodule

/* hw/rtl/xtea3_block_cipher.sv */
// XTEA3 block cipher, 128-bit block, 256-bit key, fully unrolled pipeline.
// Stages: whitening stage, one stage per round slot, output register.
// Throughput: one block per cycle; a stall freezes all stages.
// Reset (synchronous): pipeline empty, key zero, round count 64.
// Depends on xt3_pkg and xt3_round.
module xtea3_block_cipher #(
   parameter int MAX_ROUNDS = xt3_pkg::DEF_MAX_ROUNDS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [xt3_pkg::WORD_W-1:0]    req_word_a,
   input  logic [xt3_pkg::WORD_W-1:0]    req_word_b,
   input  logic [xt3_pkg::WORD_W-1:0]    req_word_c,
   input  logic [xt3_pkg::WORD_W-1:0]    req_word_d,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [xt3_pkg::WORD_W-1:0]    rsp_out_a,
   output logic [xt3_pkg::WORD_W-1:0]    rsp_out_b,
   output logic [xt3_pkg::WORD_W-1:0]    rsp_out_c,
   output logic [xt3_pkg::WORD_W-1:0]    rsp_out_d,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [xt3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [xt3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [xt3_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import xt3_pkg::*;

   localparam int RC_W = $clog2(MAX_ROUNDS + 1) > 7 ? $clog2(MAX_ROUNDS + 1) : 7;
   localparam logic [RC_W-1:0] MAX_RC = RC_W'(MAX_ROUNDS);
   localparam logic [6:0] RC_RESET = 7'd64;

   key_type           key_ff;
   logic [6:0]        rounds_ff;
   logic [RC_W-1:0]   eff_rounds;
   logic [2:0]        reg_idx;
   logic              csr_wr;

   // config registers
   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[5:3];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         rounds_ff <= RC_RESET;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_KEY01:  key_ff[1:0] <= csr_pwdata;
            REG_KEY23:  key_ff[3:2] <= csr_pwdata;
            REG_KEY45:  key_ff[5:4] <= csr_pwdata;
            REG_KEY67:  key_ff[7:6] <= csr_pwdata;
            REG_ROUNDS: rounds_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY01:  csr_prdata = key_ff[1:0];
         REG_KEY23:  csr_prdata = key_ff[3:2];
         REG_KEY45:  csr_prdata = key_ff[5:4];
         REG_KEY67:  csr_prdata = key_ff[7:6];
         REG_ROUNDS: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, rounds_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign eff_rounds = (RC_W'(rounds_ff) > MAX_RC) ? MAX_RC : RC_W'(rounds_ff);

   // pipeline stalls only when the output beat is held
   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // whitening stage
   logic              v0_ff, d0_ff;
   logic [WORD_W-1:0] s0_ff;
   block_type         b0_ff;
   logic [WORD_W-1:0] s_dec_in;
   assign s_dec_in = DELTA * WORD_W'(eff_rounds);

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (advance) v0_ff <= req_valid;
      if (advance) begin
         d0_ff <= req_cmd;
         if (req_cmd == CMD_ENC) begin
            s0_ff <= '0;
            b0_ff <= '{a: req_word_a + key_ff[0], b: req_word_b + key_ff[1],
                       c: req_word_c + key_ff[2], d: req_word_d + key_ff[3]};
         end else begin
            s0_ff <= s_dec_in;
            b0_ff <= '{a: req_word_a ^ key_ff[4], b: req_word_b ^ key_ff[5],
                       c: req_word_c ^ key_ff[6], d: req_word_d ^ key_ff[7]};
         end
      end
   end

   // round stages
   logic      [MAX_ROUNDS:0]            v_w, d_w;
   logic      [MAX_ROUNDS:0][WORD_W-1:0] s_w;
   block_type [MAX_ROUNDS:0]            b_w;
   assign v_w[0] = v0_ff;
   assign d_w[0] = d0_ff;
   assign s_w[0] = s0_ff;
   assign b_w[0] = b0_ff;

   for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_rnd
      xt3_round u_rnd (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v_w[g]),
         .dec_in    (d_w[g]),
         .active_in (RC_W'(g) < eff_rounds),
         .sum_in    (s_w[g]),
         .blk_in    (b_w[g]),
         .key       (key_ff),
         .valid_out (v_w[g+1]),
         .dec_out   (d_w[g+1]),
         .sum_out   (s_w[g+1]),
         .blk_out   (b_w[g+1])
      );
   end

   // output whitening and result register
   logic      rv_ff;
   block_type ro_ff;
   block_type last;
   assign last = b_w[MAX_ROUNDS];
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (advance) rv_ff <= v_w[MAX_ROUNDS];
      if (advance) begin
         if (d_w[MAX_ROUNDS] == CMD_ENC)
            ro_ff <= '{a: last.a ^ key_ff[4], b: last.b ^ key_ff[5],
                       c: last.c ^ key_ff[6], d: last.d ^ key_ff[7]};
         else
            ro_ff <= '{a: last.a - key_ff[0], b: last.b - key_ff[1],
                       c: last.c - key_ff[2], d: last.d - key_ff[3]};
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_a = ro_ff.a;
   assign rsp_out_b = ro_ff.b;
   assign rsp_out_c = ro_ff.c;
   assign rsp_out_d = ro_ff.d;

   // checks
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_a))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      advance && v_w[MAX_ROUNDS] |=> rsp_valid)
      else $error("beat lost at output");
endmodule

/* sim/xtea3_checker.sv */
// Scoreboard for xtea3_block_cipher: watches the request, response and CSR ports,
// predicts every block and compares it. Depends on xt3_pkg.
`timescale 1ns / 1ps
module xtea3_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [xt3_pkg::WORD_W-1:0]     req_word_a,
   input  logic [xt3_pkg::WORD_W-1:0]     req_word_b,
   input  logic [xt3_pkg::WORD_W-1:0]     req_word_c,
   input  logic [xt3_pkg::WORD_W-1:0]     req_word_d,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [xt3_pkg::WORD_W-1:0]     rsp_out_a,
   input  logic [xt3_pkg::WORD_W-1:0]     rsp_out_b,
   input  logic [xt3_pkg::WORD_W-1:0]     rsp_out_c,
   input  logic [xt3_pkg::WORD_W-1:0]     rsp_out_d,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [xt3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [xt3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             blocks_pending,
   output int                             error_count
);
   import xt3_pkg::*;

   localparam int ROUND_LIMIT = DEF_MAX_ROUNDS;

   logic [WORD_W-1:0] key_word [KEY_WORDS];
   logic [6:0]        rounds_cfg;
   block_type         expected_blocks [$];

   function automatic logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] x, logic [4:0] n);
      if (n == 0) return x;
      return (x << n) | (x >> (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] round_mix(logic [WORD_W-1:0] y,
         logic [WORD_W-1:0] z, logic [WORD_W-1:0] s, logic [1:0] pick);
      logic [WORD_W-1:0] hi_part;
      logic [WORD_W-1:0] lo_part;
      hi_part = (y << 4) + rot_left(key_word[pick + 4], y[4:0]);
      lo_part = (y >> 5) + rot_left(key_word[pick], y[31:27]);
      return hi_part ^ (z + s) ^ lo_part;
   endfunction

   // Whitening plus the round loop, forward or inverse by command.
   function automatic block_type xtea3_transform(logic cmd, block_type blk);
      logic [WORD_W-1:0] a, b, c, d, t, s;
      int n;
      n = (rounds_cfg > ROUND_LIMIT) ? ROUND_LIMIT : int'(rounds_cfg);
      if (cmd == CMD_ENC) begin
         s = '0;
         a = blk.a + key_word[0];
         b = blk.b + key_word[1];
         c = blk.c + key_word[2];
         d = blk.d + key_word[3];
         for (int i = 0; i < n; i++) begin
            a += round_mix(b, d, s, s[1:0]);
            s += DELTA;
            c += round_mix(d, b, s, s[12:11]);
            t = a; a = b; b = c; c = d; d = t;
         end
         a ^= key_word[4];
         b ^= key_word[5];
         c ^= key_word[6];
         d ^= key_word[7];
      end else begin
         s = DELTA * n;
         a = blk.a ^ key_word[4];
         b = blk.b ^ key_word[5];
         c = blk.c ^ key_word[6];
         d = blk.d ^ key_word[7];
         for (int i = 0; i < n; i++) begin
            t = d; d = c; c = b; b = a; a = t;
            c -= round_mix(d, b, s, s[12:11]);
            s -= DELTA;
            a -= round_mix(b, d, s, s[1:0]);
         end
         a -= key_word[0];
         b -= key_word[1];
         c -= key_word[2];
         d -= key_word[3];
      end
      return '{a: a, b: b, c: c, d: d};
   endfunction

   assign blocks_pending = expected_blocks.size();

   always @(posedge clock) begin
      block_type want;
      int idx;
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_word[i] = '0;
         rounds_cfg = 7'd64;
         expected_blocks.delete();
         error_count = 0;
      end else begin
         // track register writes; unknown indexes are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = csr_paddr >> 3;
            if (idx <= REG_KEY67) begin
               key_word[2*idx]     = csr_pwdata[31:0];
               key_word[2*idx + 1] = csr_pwdata[63:32];
            end else if (idx == REG_ROUNDS) begin
               rounds_cfg = csr_pwdata[6:0];
            end
         end
         if (req_valid && req_ready)
            expected_blocks.push_back(xtea3_transform(req_cmd,
               '{a: req_word_a, b: req_word_b, c: req_word_c, d: req_word_d}));
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("unexpected response beat a=%h", rsp_out_a);
               error_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_out_a !== want.a) begin
                  $error("out_a expected %h actual %h", want.a, rsp_out_a);
                  error_count++;
               end
               if (rsp_out_b !== want.b) begin
                  $error("out_b expected %h actual %h", want.b, rsp_out_b);
                  error_count++;
               end
               if (rsp_out_c !== want.c) begin
                  $error("out_c expected %h actual %h", want.c, rsp_out_c);
                  error_count++;
               end
               if (rsp_out_d !== want.d) begin
                  $error("out_d expected %h actual %h", want.d, rsp_out_d);
                  error_count++;
               end
            end
         end
      end
   end
endmodule

/* sim/testbench.sv */
// Top of the xtea3_block_cipher bench: clock, reset, stimulus and verdict.
// Depends on xt3_pkg, xtea3_block_cipher and xtea3_checker.
`timescale 1ns / 1ps
module testbench;
   import xt3_pkg::*;

   localparam int LATENCY     = DEF_MAX_ROUNDS + 2;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES      = 7;
   localparam int RANDOM_PER_PHASE = 55;

   logic clock;
   logic reset;
   logic req_valid, req_ready, req_cmd;
   logic [WORD_W-1:0] req_word_a, req_word_b, req_word_c, req_word_d;
   logic rsp_valid, rsp_ready;
   logic [WORD_W-1:0] rsp_out_a, rsp_out_b, rsp_out_c, rsp_out_d;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   int   blocks_pending, error_count;
   int   cycle_count;
   logic req_fire;
   logic quiet;
   int   stall_left;

   xtea3_block_cipher dut (.*);
   xtea3_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // catch a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) req_fire <= req_valid && req_ready;

   // response back-pressure in bursts, none once the run goes quiet
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 15);
      end
   end

   task automatic csr_write(logic [2:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = CSR_ADDR_W'(index) << 3; csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   // drop the request, then hold until every block is back and the pipeline has drained
   task automatic drain;
      req_valid = 1'b0;
      while (blocks_pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic send_block(logic cmd, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                             logic [WORD_W-1:0] c, logic [WORD_W-1:0] d);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid = 1'b1; req_cmd = cmd;
      req_word_a = a; req_word_b = b; req_word_c = c; req_word_d = d;
      do @(negedge clock); while (!req_fire);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic configure(logic [CSR_DATA_W-1:0] k01, logic [CSR_DATA_W-1:0] k23,
                            logic [CSR_DATA_W-1:0] k45, logic [CSR_DATA_W-1:0] k67,
                            logic [6:0] rounds);
      csr_write(REG_KEY01, k01);
      csr_write(REG_KEY23, k23);
      csr_write(REG_KEY45, k45);
      csr_write(REG_KEY67, k67);
      csr_write(REG_ROUNDS, CSR_DATA_W'(rounds));
      // index past the last register must be dropped
      csr_write(3'd5, {$urandom(), $urandom()});
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rk [4];
      logic [6:0] rounds;
      reset = 1'b1; quiet = 1'b0; stall_left = 0; cycle_count = 0;
      req_valid = 1'b0; req_cmd = CMD_ENC;
      req_word_a = '0; req_word_b = '0; req_word_c = '0; req_word_d = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed blocks under the reset key and round count
      send_block(CMD_ENC, '0, '0, '0, '0);
      send_block(CMD_DEC, '0, '0, '0, '0);
      send_block(CMD_ENC, '1, '1, '1, '1);
      send_block(CMD_DEC, '1, '1, '1, '1);
      send_block(CMD_ENC, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(CMD_DEC, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      send_block(CMD_ENC, 32'h0000_0020, 32'hFFFF_FFE0, 32'h0800_0000, 32'h0000_0001);
      send_block(CMD_DEC, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
      drain();
      configure({32'hFFFF_FFFF, 32'h0}, {32'h0, 32'hFFFF_FFFF},
                {32'h1, 32'h8000_0000}, {32'hDEAD_BEEF, 32'h0}, 7'd0);
      send_block(CMD_ENC, '1, '0, 32'h1234_5678, 32'h8000_0000);
      send_block(CMD_DEC, '1, '0, 32'h1234_5678, 32'h8000_0000);
      drain();
      configure('1, '1, '1, '1, 7'd127);
      send_block(CMD_ENC, '0, '1, '0, '1);
      send_block(CMD_DEC, '0, '1, '0, '1);
      send_block(CMD_ENC, 32'h0000_001F, 32'hF800_0000, '0, '1);
      drain();

      // random phases sweeping the round count, extremes included
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: rounds = 7'd0;
            1: rounds = 7'd1;
            2: rounds = 7'd64;
            3: rounds = 7'd127;
            4: rounds = 7'd65;
            default: rounds = 7'($urandom_range(2, 63));
         endcase
         for (int k = 0; k < 4; k++)
            case ($urandom_range(0, 5))
               0: rk[k] = '0;
               1: rk[k] = '1;
               default: rk[k] = {$urandom(), $urandom()};
            endcase
         configure(rk[0], rk[1], rk[2], rk[3], rounds);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (ph == PHASES - 1 && i >= RANDOM_PER_PHASE - 30) quiet = 1'b1;
            send_block(1'($urandom_range(0, 1)), pick_word(), pick_word(),
                       pick_word(), pick_word());
         end
         req_valid = 1'b0;
         drain();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* files.f */
hw/rtl/xt3_pkg.sv
hw/rtl/xt3_round.sv
hw/rtl/xtea3_block_cipher.sv
sim/xtea3_checker.sv
sim/testbench.sv
